// ----- design/dual_white_lamp_key_dimmer_defines.svh -----
// Assertion macros shared by the dimmer checker.
// Depends on nothing; expects signals named clock and reset where used.
`ifndef DUAL_WHITE_LAMP_KEY_DIMMER_DEFINES_SVH
`define DUAL_WHITE_LAMP_KEY_DIMMER_DEFINES_SVH

// Clocked check, muted while reset is high.
`define DWLKD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DWLKD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/dwlkd_pkg.sv -----
// Shared types, codes and reset values for the dual white lamp key dimmer.
// Depends on nothing; used by every RTL file of the block.
package dwlkd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MIN         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MAX         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_BRIGHTNESS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_BATTERY_LEVEL = 3'd4;

   // Request command codes
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_EDGE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   // Lamp modes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_COOL = 2'd1;
   localparam logic [1:0] MODE_WARM = 2'd2;
   localparam logic [1:0] MODE_BOTH = 2'd3;

   localparam logic [7:0] BRIGHT_FULL = 8'd255;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] pulse_width;
      logic        charging_n;
      logic [11:0] battery_sample;
   } req_type;

   typedef struct packed {
      logic [7:0] duty_warm;
      logic [7:0] duty_cool;
      logic       led_charge;
      logic       led_low;
      logic [1:0] lamp_mode;
   } rsp_type;

   typedef struct packed {
      logic [15:0] width_min;
      logic [15:0] width_max;
      logic [6:0]  long_press_ticks;
      logic [7:0]  min_brightness;
      logic [11:0] low_battery_level;
   } cfg_type;

   typedef struct packed {
      logic       measure_running;
      logic       key_held;
      logic [6:0] press_count;
      logic       long_press;
      logic       dim_down;
      logic [7:0] brightness;
      logic [1:0] mode;
      logic [7:0] warm_duty;
      logic [7:0] cool_duty;
      logic       low_lamp;
      logic       charge_lamp;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      width_min:         16'd0,
      width_max:         16'hFFFF,
      long_press_ticks:  7'd100,
      min_brightness:    8'd25,
      low_battery_level: 12'h22D
   };

   localparam state_type STATE_RESET = '{
      measure_running: 1'b0,
      key_held:        1'b0,
      press_count:     7'd0,
      long_press:      1'b0,
      dim_down:        1'b0,
      brightness:      BRIGHT_FULL,
      mode:            MODE_OFF,
      warm_duty:       8'd0,
      cool_duty:       8'd0,
      low_lamp:        1'b0,
      charge_lamp:     1'b0
   };

endpackage

// ----- design/dwlkd_step.sv -----
// Next-state logic of the dimmer for one request: key, PWM slew and lamps.
// Depends on dwlkd_pkg.
module dwlkd_step (
   input  dwlkd_pkg::state_type state_cur,
   input  dwlkd_pkg::cfg_type   cfg,
   input  dwlkd_pkg::req_type   req,
   output dwlkd_pkg::state_type state_next,
   output dwlkd_pkg::rsp_type   rsp_next
);

   function automatic logic [7:0] slew(input logic [7:0] cur, input logic [7:0] target);
      logic [7:0] res;
      res = cur;
      if (target > cur) begin
         res = cur + 8'd1;
      end else if (target < cur) begin
         res = cur - 8'd1;
      end
      return res;
   endfunction

   always_comb begin
      dwlkd_pkg::state_type s;
      logic [7:0] tgt_warm;
      logic [7:0] tgt_cool;
      s = state_cur;
      tgt_warm = 8'd0;
      tgt_cool = 8'd0;
      case (req.cmd)
         dwlkd_pkg::CMD_TICK: begin
            // key: count the hold, then ramp; on release cycle mode or flip ramp
            if (s.key_held) begin
               if (s.press_count < cfg.long_press_ticks) begin
                  s.press_count = s.press_count + 7'd1;
               end else begin
                  s.long_press = 1'b1;
                  if (s.dim_down) begin
                     if (s.brightness > cfg.min_brightness) begin
                        s.brightness = s.brightness - 8'd1;
                     end
                  end else if (s.brightness < dwlkd_pkg::BRIGHT_FULL) begin
                     s.brightness = s.brightness + 8'd1;
                  end
               end
            end else if (s.press_count != 7'd0) begin
               s.press_count = 7'd0;
               if (!s.long_press) begin
                  if (s.mode == dwlkd_pkg::MODE_BOTH) begin
                     s.mode       = dwlkd_pkg::MODE_OFF;
                     s.brightness = dwlkd_pkg::BRIGHT_FULL;
                     s.dim_down   = 1'b1;
                  end else begin
                     s.mode = s.mode + 2'd1;
                  end
               end else begin
                  s.dim_down = ~s.dim_down;
               end
               s.long_press = 1'b0;
            end
            // PWM targets follow the new mode
            case (s.mode)
               dwlkd_pkg::MODE_COOL: tgt_cool = s.brightness;
               dwlkd_pkg::MODE_WARM: tgt_warm = s.brightness;
               dwlkd_pkg::MODE_BOTH: begin
                  tgt_cool = s.brightness;
                  tgt_warm = s.brightness;
               end
               default: ;
            endcase
            s.warm_duty = slew(s.warm_duty, tgt_warm);
            s.cool_duty = slew(s.cool_duty, tgt_cool);
            // indicator lamps
            if (!req.charging_n) begin
               s.charge_lamp = 1'b1;
               s.low_lamp    = 1'b0;
            end else begin
               s.charge_lamp = 1'b0;
               if (s.mode == dwlkd_pkg::MODE_OFF) begin
                  s.low_lamp = 1'b0;
               end else if (req.battery_sample <= cfg.low_battery_level) begin
                  s.low_lamp = 1'b1;
               end
            end
         end
         dwlkd_pkg::CMD_EDGE: begin
            if (s.measure_running) begin
               s.key_held = (req.pulse_width >= cfg.width_min) &&
                            (req.pulse_width <= cfg.width_max);
            end
            s.measure_running = 1'b1;
         end
         dwlkd_pkg::CMD_TIMEOUT: begin
            s.measure_running = 1'b0;
            s.key_held        = 1'b0;
         end
         default: ;
      endcase
      state_next = s;
      rsp_next.duty_warm  = s.warm_duty;
      rsp_next.duty_cool  = s.cool_duty;
      rsp_next.led_charge = s.charge_lamp;
      rsp_next.led_low    = s.low_lamp;
      rsp_next.lamp_mode  = s.mode;
   end

endmodule

// ----- design/dual_white_lamp_key_dimmer.sv -----
// Top level of the dual white lamp key dimmer: handshake, state and config registers.
// Depends on dwlkd_pkg and dwlkd_step.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one request per event:
//   a 5 ms tick, a key edge with its measured pulse width, or a pulse timeout.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one response per
//   request: both PWM duties, the charge and low battery lamps and the mode,
//   as they stand after that request.
//   csr_write_en/csr_index/csr_wdata write one of the five setup registers per
//   write; write them only while no request is in flight.
// Timing: a request accepted into the input register passes through the
//   combinational state update into the response register and shows on rsp
//   once that register is free or draining. Throughput: one request per cycle
//   while rsp is not stalled, as the state update between the two registers is combinational.
// Reset (synchronous, active high) empties both registers, restores the
//   setup registers to their defaults and returns the lamp to off, full
//   brightness, no key held.
// Stall: while rsp_valid is high and rsp_ready low the response holds; the
//   input register still takes one more request, then req_ready drops.
module dual_white_lamp_key_dimmer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  dwlkd_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output dwlkd_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_write_en,
   input  logic [dwlkd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dwlkd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   dwlkd_pkg::req_type   in_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   dwlkd_pkg::rsp_type   rsp_ff;
   dwlkd_pkg::state_type state_ff;
   dwlkd_pkg::state_type state_in;
   dwlkd_pkg::cfg_type   cfg_ff;
   dwlkd_pkg::cfg_type   cfg_in;
   dwlkd_pkg::state_type step_state;
   dwlkd_pkg::rsp_type   step_rsp;
   logic                 advance;
   logic                 fire;
   logic                 take;

   // advance the input stage whenever the response register is free or draining
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   assign state_in     = fire ? step_state : state_ff;

   dwlkd_step u_step (
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .req        (in_ff),
      .state_next (step_state),
      .rsp_next   (step_rsp)
   );

   // setup register writes; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            dwlkd_pkg::CSR_WIDTH_MIN:         cfg_in.width_min = csr_wdata;
            dwlkd_pkg::CSR_WIDTH_MAX:         cfg_in.width_max = csr_wdata;
            dwlkd_pkg::CSR_LONG_PRESS_TICKS:  cfg_in.long_press_ticks = csr_wdata[6:0];
            dwlkd_pkg::CSR_MIN_BRIGHTNESS:    cfg_in.min_brightness = csr_wdata[7:0];
            dwlkd_pkg::CSR_LOW_BATTERY_LEVEL: cfg_in.low_battery_level = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // control and lamp state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= dwlkd_pkg::STATE_RESET;
         cfg_ff       <= dwlkd_pkg::CFG_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers: load on handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/dwlkd_checker.sv -----
// Port-level checker for the dimmer, bound to the top level.
// Depends on dwlkd_pkg and dual_white_lamp_key_dimmer_defines.svh.
`include "dual_white_lamp_key_dimmer_defines.svh"

module dwlkd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input dwlkd_pkg::req_type                req_data,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input dwlkd_pkg::rsp_type                rsp_data,
   input logic                              csr_write_en,
   input logic [dwlkd_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [dwlkd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   `DWLKD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response changed")
   `DWLKD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")
   `DWLKD_ASSERT(a_lamps_exclusive, rsp_valid |-> !(rsp_data.led_charge && rsp_data.led_low), "charge and low lamps both on")
   `DWLKD_ASSERT(a_off_no_low, rsp_valid && rsp_data.lamp_mode == dwlkd_pkg::MODE_OFF |-> !rsp_data.led_low, "low lamp on with lamp off")
   `DWLKD_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "request refused with empty response stage")

endmodule

bind dual_white_lamp_key_dimmer dwlkd_checker u_dwlkd_checker (.*);
